// ----- rtl/feedback_arc_set_ordering_top_defines.svh -----
// assertion macros for the feedback arc set ordering block
`ifndef FEEDBACK_ARC_SET_ORDERING_TOP_DEFINES_SVH
`define FEEDBACK_ARC_SET_ORDERING_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define FASO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after reset, reset itself not masked
`define FASO_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- rtl/faso_pkg.sv -----
// shared types and constants of the feedback arc set ordering block
`default_nettype none
package faso_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;
   localparam int MAG_W      = 31;
   localparam int STR_W      = 38;
   localparam int NC_W       = 7;

   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'b1;

   localparam logic [MAG_W-1:0] MAG_MAX = 31'h7FFF_FFFF;
   localparam logic [NC_W-1:0]  NODE_COUNT_RESET = 7'd32;

   typedef struct packed {
      logic signed [31:0] entry_value;
      logic               last_entry;
   } req_type;

   typedef struct packed {
      logic [5:0] position;
      logic [5:0] node_at_position;
      logic       last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_BUILD,
      S_CLASSIFY,
      S_SRC_POP,
      S_DROP_OUT_SRC,
      S_SNK_POP,
      S_DROP_IN_SNK,
      S_MAX_SCAN,
      S_PLACE_MAX,
      S_DROP_OUT_MAX,
      S_DROP_IN_MAX,
      S_EMIT
   } fsm_state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_CLEAR,
      DP_BUILD,
      DP_CLASSIFY,
      DP_SRC_POP,
      DP_SNK_POP,
      DP_MAX_SCAN,
      DP_PLACE_MAX,
      DP_DROP_OUT,
      DP_DROP_IN,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic stack_empty;
      logic placed;
      logic found;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/faso_ctrl.sv -----
// sequencer of the feedback arc set ordering block
`default_nettype none
module faso_ctrl import faso_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_last,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_last) state_in = S_CLEAR;
         end
         S_CLEAR:    state_in = S_BUILD;
         S_BUILD: begin
            if (status.done) state_in = S_CLASSIFY;
         end
         S_CLASSIFY: begin
            if (status.done) state_in = S_SRC_POP;
         end
         S_SRC_POP: begin
            if (status.stack_empty) state_in = S_SNK_POP;
            else if (status.placed) state_in = S_DROP_OUT_SRC;
         end
         S_DROP_OUT_SRC: begin
            if (status.done) state_in = S_SRC_POP;
         end
         S_SNK_POP: begin
            if (status.stack_empty) state_in = S_MAX_SCAN;
            else if (status.placed) state_in = S_DROP_IN_SNK;
         end
         S_DROP_IN_SNK: begin
            if (status.done) state_in = S_SNK_POP;
         end
         S_MAX_SCAN: begin
            if (status.done) state_in = status.found ? S_PLACE_MAX : S_EMIT;
         end
         S_PLACE_MAX:    state_in = S_DROP_OUT_MAX;
         S_DROP_OUT_MAX: begin
            if (status.done) state_in = S_DROP_IN_MAX;
         end
         S_DROP_IN_MAX: begin
            if (status.done) state_in = S_SRC_POP;
         end
         S_EMIT: begin
            if (status.done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load = 1'b0;
      cmd.op   = DP_IDLE;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_CLEAR:        cmd.op = DP_CLEAR;
         S_BUILD:        cmd.op = DP_BUILD;
         S_CLASSIFY:     cmd.op = DP_CLASSIFY;
         S_SRC_POP:      cmd.op = DP_SRC_POP;
         S_DROP_OUT_SRC: cmd.op = DP_DROP_OUT;
         S_SNK_POP:      cmd.op = DP_SNK_POP;
         S_DROP_IN_SNK:  cmd.op = DP_DROP_IN;
         S_MAX_SCAN:     cmd.op = DP_MAX_SCAN;
         S_PLACE_MAX:    cmd.op = DP_PLACE_MAX;
         S_DROP_OUT_MAX: cmd.op = DP_DROP_OUT;
         S_DROP_IN_MAX:  cmd.op = DP_DROP_IN;
         S_EMIT:         cmd.op = DP_EMIT;
         default:        cmd.op = DP_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/faso_dpath.sv -----
// matrix store, node tables, stacks and scan counters of the ordering block
`default_nettype none
module faso_dpath import faso_pkg::*; #(
   parameter int MAX_NODES  = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  req_type               req_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output dp_status_type         status,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload
);

   localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCNT_W = $clog2(MAX_NODES + 1);
   localparam int CELLS  = MAX_NODES * MAX_NODES;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int LIDX_W = $clog2(CELLS + 1);
   localparam int SQ_W   = 2 * NCNT_W;
   localparam int CW     = SQ_W + LIDX_W;
   localparam int D_W    = STR_W + 1;

   // configuration
   logic [NC_W-1:0]  node_count_ff, node_count_in;
   logic [MAG_W-1:0] thr_ff, thr_in;
   logic [NCNT_W-1:0] n_eff;
   logic [SQ_W-1:0]   n_sq;

   // matrix store
   logic [MAG_W-1:0]  mem [CELLS];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [MAG_W-1:0]  mem_wdata, rdata_ff;
   logic [LIDX_W-1:0] load_idx_ff, load_idx_in;

   // magnitude of the incoming entry
   logic [47:0]           ext;
   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS:0]   magf;
   logic [48:0]           magw;

   // scan control
   dp_op_type         op_prev_ff;
   logic              first, issue, is_mem;
   logic [SQ_W-1:0]   cnt_ff, cnt_in, cnt_eff, lim;
   logic [ADDR_W:0]   addr_ff, addr_in, a_eff;
   logic [NCNT_W-1:0] r_ff, r_in, c_ff, c_in, r_eff, c_eff;
   logic              rd_valid_ff, rd_valid_in, diag_ff, diag_in;
   logic [NODE_W-1:0] kd_ff, kd_in, rr_ff, rr_in, rc_ff, rc_in, k;
   logic              edge_hit;
   logic [MAG_W-1:0]  w;

   // node tables
   logic [NCNT_W-1:0] in_deg_ff  [MAX_NODES], in_deg_in  [MAX_NODES];
   logic [NCNT_W-1:0] out_deg_ff [MAX_NODES], out_deg_in [MAX_NODES];
   logic [STR_W-1:0]  in_str_ff  [MAX_NODES], in_str_in  [MAX_NODES];
   logic [STR_W-1:0]  out_str_ff [MAX_NODES], out_str_in [MAX_NODES];
   logic              gone_ff    [MAX_NODES], gone_in    [MAX_NODES];
   logic [NODE_W-1:0] node_of_ff [MAX_NODES], node_of_in [MAX_NODES];
   logic [NODE_W-1:0] src_stk_ff [MAX_NODES], src_stk_in [MAX_NODES];
   logic [NODE_W-1:0] snk_stk_ff [MAX_NODES], snk_stk_in [MAX_NODES];
   logic [NCNT_W-1:0] ssrc_ff, ssrc_in, ssnk_ff, ssnk_in;
   logic [NCNT_W-1:0] front_ff, front_in, back_ff, back_in;
   logic [NODE_W-1:0] v_ff, v_in, best_v_ff, best_v_in;
   logic [ADDR_W:0]   vn_ff, vn_in;
   logic signed [D_W-1:0] best_ff, best_in, best_cur, d;
   logic              found_ff, found_in, found_cur;
   logic [NODE_W-1:0] src_top, snk_top;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   always_comb begin
      if (node_count_ff == '0) n_eff = NCNT_W'(1);
      else if (node_count_ff > NC_W'(MAX_NODES)) n_eff = NCNT_W'(MAX_NODES);
      else n_eff = NCNT_W'(node_count_ff);
   end
   assign n_sq = SQ_W'(n_eff) * SQ_W'(n_eff);

   // two's complement magnitude, saturated to the 31 bit range
   always_comb begin
      ext  = {16'b0, req_payload.entry_value};
      raw  = ext[VALUE_BITS-1:0];
      magf = raw[VALUE_BITS-1] ? ({1'b0, ~raw} + (VALUE_BITS+1)'(1)) : {1'b0, raw};
      magw = 49'(magf);
      mem_wdata = (magw > 49'(MAG_MAX)) ? MAG_MAX : magw[MAG_W-1:0];
   end

   assign first   = (cmd.op != op_prev_ff);
   assign is_mem  = (cmd.op == DP_BUILD) || (cmd.op == DP_DROP_OUT) ||
                    (cmd.op == DP_DROP_IN);
   assign cnt_eff = first ? '0 : cnt_ff;
   assign lim     = (cmd.op == DP_BUILD) ? n_sq : SQ_W'(n_eff);
   assign issue   = (cnt_eff < lim);
   assign k       = cnt_eff[NODE_W-1:0];
   assign r_eff   = first ? '0 : r_ff;
   assign c_eff   = first ? '0 : c_ff;
   assign src_top = src_stk_ff[NODE_W'(ssrc_ff - NCNT_W'(1))];
   assign snk_top = snk_stk_ff[NODE_W'(ssnk_ff - NCNT_W'(1))];
   assign best_cur  = first ? '0 : best_ff;
   assign found_cur = first ? 1'b0 : found_ff;

   always_comb begin
      case (cmd.op)
         DP_DROP_OUT: a_eff = first ? (ADDR_W+1)'(v_ff) : addr_ff;
         DP_DROP_IN:  a_eff = first ? vn_ff : addr_ff;
         default:     a_eff = first ? '0 : addr_ff;
      endcase
   end
   assign mem_raddr = a_eff[ADDR_W-1:0];

   // weight of the cell read in the previous cycle
   assign edge_hit = rd_valid_ff && !first && !diag_ff && (rdata_ff > thr_ff);
   assign w        = edge_hit ? rdata_ff : '0;
   assign d = signed'({1'b0, out_str_ff[k]}) - signed'({1'b0, in_str_ff[k]});

   always_comb begin
      node_count_in = node_count_ff;
      thr_in        = thr_ff;
      load_idx_in   = load_idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = load_idx_ff[ADDR_W-1:0];
      cnt_in        = issue ? cnt_eff + SQ_W'(1) : cnt_eff;
      addr_in       = a_eff;
      r_in          = r_eff;
      c_in          = c_eff;
      rd_valid_in   = is_mem && issue;
      diag_in       = 1'b0;
      kd_in         = k;
      rr_in         = r_eff[NODE_W-1:0];
      rc_in         = c_eff[NODE_W-1:0];
      in_deg_in     = in_deg_ff;
      out_deg_in    = out_deg_ff;
      in_str_in     = in_str_ff;
      out_str_in    = out_str_ff;
      gone_in       = gone_ff;
      node_of_in    = node_of_ff;
      src_stk_in    = src_stk_ff;
      snk_stk_in    = snk_stk_ff;
      ssrc_in       = ssrc_ff;
      ssnk_in       = ssnk_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      v_in          = v_ff;
      vn_in         = vn_ff;
      best_in       = best_cur;
      best_v_in     = best_v_ff;
      found_in      = found_cur;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            REG_NODE_COUNT:     node_count_in = csr_wdata[NC_W-1:0];
            REG_EDGE_THRESHOLD: thr_in = csr_wdata[MAG_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         mem_we = (CW'(load_idx_ff) < CW'(n_sq));
         if (load_idx_ff != LIDX_W'(CELLS)) load_idx_in = load_idx_ff + LIDX_W'(1);
         if (req_payload.last_entry) load_idx_in = '0;
      end

      case (cmd.op)
         DP_CLEAR: begin
            for (int i = 0; i < MAX_NODES; i++) begin
               in_deg_in[i]  = '0;
               out_deg_in[i] = '0;
               in_str_in[i]  = '0;
               out_str_in[i] = '0;
               gone_in[i]    = 1'b0;
               node_of_in[i] = '0;
            end
            ssrc_in  = '0;
            ssnk_in  = '0;
            front_in = '0;
            back_in  = n_eff - NCNT_W'(1);
         end
         DP_BUILD: begin
            addr_in = issue ? a_eff + (ADDR_W+1)'(1) : a_eff;
            diag_in = (r_eff == c_eff);
            if (issue) begin
               if (r_eff == n_eff - NCNT_W'(1)) begin
                  r_in = '0;
                  c_in = c_eff + NCNT_W'(1);
               end else begin
                  r_in = r_eff + NCNT_W'(1);
               end
            end
            if (edge_hit) begin
               out_deg_in[rr_ff] = out_deg_ff[rr_ff] + NCNT_W'(1);
               out_str_in[rr_ff] = out_str_ff[rr_ff] + STR_W'(w);
               in_deg_in[rc_ff]  = in_deg_ff[rc_ff] + NCNT_W'(1);
               in_str_in[rc_ff]  = in_str_ff[rc_ff] + STR_W'(w);
            end
         end
         DP_CLASSIFY: begin
            if (issue) begin
               if (in_deg_ff[k] == '0 && out_deg_ff[k] == '0) begin
                  gone_in[k] = 1'b1;
                  node_of_in[front_ff[NODE_W-1:0]] = k;
                  front_in = front_ff + NCNT_W'(1);
               end else if (in_deg_ff[k] == '0) begin
                  src_stk_in[ssrc_ff[NODE_W-1:0]] = k;
                  ssrc_in = ssrc_ff + NCNT_W'(1);
               end else if (out_deg_ff[k] == '0) begin
                  snk_stk_in[ssnk_ff[NODE_W-1:0]] = k;
                  ssnk_in = ssnk_ff + NCNT_W'(1);
               end
            end
         end
         DP_SRC_POP: begin
            if (ssrc_ff != '0) begin
               ssrc_in = ssrc_ff - NCNT_W'(1);
               if (!gone_ff[src_top]) begin
                  gone_in[src_top] = 1'b1;
                  node_of_in[front_ff[NODE_W-1:0]] = src_top;
                  front_in = front_ff + NCNT_W'(1);
                  v_in  = src_top;
                  vn_in = (ADDR_W+1)'(src_top) * (ADDR_W+1)'(n_eff);
               end
            end
         end
         DP_SNK_POP: begin
            if (ssnk_ff != '0) begin
               ssnk_in = ssnk_ff - NCNT_W'(1);
               if (!gone_ff[snk_top]) begin
                  gone_in[snk_top] = 1'b1;
                  node_of_in[back_ff[NODE_W-1:0]] = snk_top;
                  back_in = back_ff - NCNT_W'(1);
                  v_in  = snk_top;
                  vn_in = (ADDR_W+1)'(snk_top) * (ADDR_W+1)'(n_eff);
               end
            end
         end
         DP_MAX_SCAN: begin
            if (issue && !gone_ff[k]) begin
               if (!found_cur || d > best_cur) begin
                  best_in   = d;
                  best_v_in = k;
                  found_in  = 1'b1;
               end
            end
         end
         DP_PLACE_MAX: begin
            gone_in[best_v_ff] = 1'b1;
            node_of_in[front_ff[NODE_W-1:0]] = best_v_ff;
            front_in = front_ff + NCNT_W'(1);
            v_in  = best_v_ff;
            vn_in = (ADDR_W+1)'(best_v_ff) * (ADDR_W+1)'(n_eff);
         end
         DP_DROP_OUT: begin
            // row v, walking the columns
            addr_in = issue ? a_eff + (ADDR_W+1)'(n_eff) : a_eff;
            diag_in = (k == v_ff);
            if (edge_hit && !gone_ff[kd_ff] && in_deg_ff[kd_ff] != '0) begin
               in_deg_in[kd_ff] = in_deg_ff[kd_ff] - NCNT_W'(1);
               in_str_in[kd_ff] = in_str_ff[kd_ff] - STR_W'(w);
               if (in_deg_ff[kd_ff] == NCNT_W'(1) && ssrc_ff < NCNT_W'(MAX_NODES)) begin
                  src_stk_in[ssrc_ff[NODE_W-1:0]] = kd_ff;
                  ssrc_in = ssrc_ff + NCNT_W'(1);
               end
            end
         end
         DP_DROP_IN: begin
            // column v, walking the rows
            addr_in = issue ? a_eff + (ADDR_W+1)'(1) : a_eff;
            diag_in = (k == v_ff);
            if (edge_hit && !gone_ff[kd_ff] && out_deg_ff[kd_ff] != '0) begin
               out_deg_in[kd_ff] = out_deg_ff[kd_ff] - NCNT_W'(1);
               out_str_in[kd_ff] = out_str_ff[kd_ff] - STR_W'(w);
               if (out_deg_ff[kd_ff] == NCNT_W'(1) && ssnk_ff < NCNT_W'(MAX_NODES)) begin
                  snk_stk_in[ssnk_ff[NODE_W-1:0]] = kd_ff;
                  ssnk_in = ssnk_ff + NCNT_W'(1);
               end
            end
         end
         DP_EMIT: begin
            if (issue) begin
               rsp_valid_in                 = 1'b1;
               rsp_in.position              = 6'(cnt_eff);
               rsp_in.node_at_position      = 6'(node_of_ff[k]);
               rsp_in.last_result           = (cnt_eff == SQ_W'(n_eff) - SQ_W'(1));
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      status.done        = is_mem ? (!issue && (first || !rd_valid_ff)) : !issue;
      status.stack_empty = (cmd.op == DP_SNK_POP) ? (ssnk_ff == '0) : (ssrc_ff == '0);
      status.placed      = (cmd.op == DP_SNK_POP) ? (ssnk_ff != '0 && !gone_ff[snk_top])
                                                  : (ssrc_ff != '0 && !gone_ff[src_top]);
      status.found       = found_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         thr_ff        <= '0;
         load_idx_ff   <= '0;
         op_prev_ff    <= DP_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         thr_ff        <= thr_in;
         load_idx_ff   <= load_idx_in;
         op_prev_ff    <= cmd.op;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      addr_ff    <= addr_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      diag_ff    <= diag_in;
      kd_ff      <= kd_in;
      rr_ff      <= rr_in;
      rc_ff      <= rc_in;
      in_deg_ff  <= in_deg_in;
      out_deg_ff <= out_deg_in;
      in_str_ff  <= in_str_in;
      out_str_ff <= out_str_in;
      gone_ff    <= gone_in;
      node_of_ff <= node_of_in;
      src_stk_ff <= src_stk_in;
      snk_stk_ff <= snk_stk_in;
      ssrc_ff    <= ssrc_in;
      ssnk_ff    <= ssnk_in;
      front_ff   <= front_in;
      back_ff    <= back_in;
      v_ff       <= v_in;
      vn_ff      <= vn_in;
      best_ff    <= best_in;
      best_v_ff  <= best_v_in;
      found_ff   <= found_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/feedback_arc_set_ordering_top.sv -----
// top level of the feedback arc set ordering block
//
// usage
//   csr port: csr_we writes csr_wdata to register csr_index (node count,
//   edge threshold) at the clock edge; the user must write only while busy
//   is low, as the block itself does not enforce it
//   request channel: a matrix entry is taken at an edge with start high and
//   busy low, one entry per cycle, column-major with the row index fastest
//   the entry flagged last_entry kicks off the ordering and raises busy
//   result channel: n results, one per cycle on rsp_valid, positions 0 to
//   n-1 in order, last_result on the final one; the receiver cannot stall
// ordering steps
//   tally degrees through the single matrix read port, classify, then per
//   removed node a source or sink pop with one row or column sweep, or a
//   strength search with a row and a column sweep, then emit the n results
// reset
//   synchronous; clears the load pointer, the sequencer and the registers
//   (node count 32, threshold 0); the matrix store keeps no reset value
`default_nettype none
module feedback_arc_set_ordering_top import faso_pkg::*; #(
   parameter int MAX_NODES  = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   faso_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_payload.last_entry),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   faso_dpath #(
      .MAX_NODES  (MAX_NODES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- rtl/faso_checker.sv -----
// port level checks of the ordering block and their binding
`default_nettype none
`include "feedback_arc_set_ordering_top_defines.svh"
module faso_checker import faso_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input req_type               req_payload,
   input logic                  rsp_valid,
   input rsp_type               rsp_payload,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   `FASO_ASSERT_NEXT(a_last_starts, clock, reset, start && !busy && req_payload.last_entry, busy, "last request did not start ordering")
   `FASO_ASSERT_NEXT(a_pos_step, clock, reset, rsp_valid && !rsp_payload.last_result, rsp_valid && (rsp_payload.position == $past(rsp_payload.position) + 6'd1), "result positions not consecutive")
   `FASO_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_payload.last_result, !rsp_valid, "result after final position")
   `FASO_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !busy && !rsp_valid, "not idle after reset")

endmodule

bind feedback_arc_set_ordering_top faso_checker u_faso_checker (.*);
`default_nettype wire
